>>> src/cwm_pkg.sv
// Shared constants, state encoding and divider interface types for the
// centered window mean block. No dependencies.
package cwm_pkg;

   localparam int MAX_RADIUS   = 15;
   localparam int SAMPLE_BITS  = 16;
   localparam int LINE_DEPTH   = 2 * MAX_RADIUS + 1;
   localparam int RADIUS_BITS  = 4;
   localparam int RADIUS_RESET = 1;
   localparam int COUNT_BITS   = $clog2(LINE_DEPTH + 1);
   localparam int AGE_BITS     = $clog2(LINE_DEPTH);
   localparam int FRAC_BITS    = 8;
   localparam int SUM_BITS     = SAMPLE_BITS + COUNT_BITS;
   localparam int MAG_BITS     = SUM_BITS - 1;
   localparam int QUOT_BITS    = SAMPLE_BITS + FRAC_BITS;
   localparam int STEP_BITS    = $clog2(QUOT_BITS);
   localparam int MEAN_BITS    = 24;
   localparam int MEMBERS_BITS = 5;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ACCUM,
      ST_LAUNCH,
      ST_DIVIDE
   } cwm_state_type;

   typedef struct packed {
      logic                         start;
      logic signed [SUM_BITS-1:0]   sum;
      logic [COUNT_BITS-1:0]        count;
   } div_req_type;

   typedef struct packed {
      logic                         done;
      logic signed [QUOT_BITS:0]    quot;
   } div_rsp_type;

endpackage

>>> src/cwm_line.sv
// Sample shift line: newest sample at age 0, read at one selected age.
// Depends on cwm_pkg.
module cwm_line (
   input  logic                                   clock,
   input  logic                                   push,
   input  logic signed [cwm_pkg::SAMPLE_BITS-1:0] push_data,
   input  logic [cwm_pkg::AGE_BITS-1:0]           rd_age,
   output logic signed [cwm_pkg::SAMPLE_BITS-1:0] rd_data
);
   import cwm_pkg::*;

   logic signed [SAMPLE_BITS-1:0] line_ff [LINE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] line_in [LINE_DEPTH];

   always_comb begin
      line_in[0] = push_data;
      for (int i = 1; i < LINE_DEPTH; i++) begin
         line_in[i] = line_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         line_ff <= line_in;
      end
   end

   assign rd_data = line_ff[rd_age];

endmodule

>>> src/cwm_div.sv
// Bit-serial restoring divider: signed window sum times 256 over the member
// count, one quotient bit per cycle, truncated toward zero. Depends on cwm_pkg.
module cwm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  cwm_pkg::div_req_type div_req,
   output cwm_pkg::div_rsp_type div_rsp
);
   import cwm_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic                  neg_ff, neg_in;
   logic [STEP_BITS-1:0]  step_ff, step_in;
   logic [COUNT_BITS-1:0] rem_ff, rem_in;
   logic [COUNT_BITS-1:0] den_ff, den_in;
   logic [QUOT_BITS-1:0]  shreg_ff, shreg_in;

   logic [SUM_BITS-1:0]   mag_full;
   logic [MAG_BITS-1:0]   mag;
   logic [COUNT_BITS:0]   shifted;
   logic [COUNT_BITS:0]   trial;
   logic                  fits;
   logic signed [QUOT_BITS:0] quot_mag;

   assign mag_full = div_req.sum[SUM_BITS-1] ? SUM_BITS'(-div_req.sum) : div_req.sum;
   assign mag      = mag_full[MAG_BITS-1:0];
   assign shifted  = {rem_ff, shreg_ff[QUOT_BITS-1]};
   assign trial    = shifted - {1'b0, den_ff};
   assign fits     = !trial[COUNT_BITS];

   always_comb begin
      busy_in  = busy_ff;
      done_in  = done_ff;
      neg_in   = neg_ff;
      step_in  = step_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      shreg_in = shreg_ff;
      if (div_req.start) begin
         busy_in  = 1'b1;
         done_in  = 1'b0;
         neg_in   = div_req.sum[SUM_BITS-1];
         step_in  = '0;
         rem_in   = COUNT_BITS'(mag[MAG_BITS-1:SAMPLE_BITS]);
         den_in   = div_req.count;
         shreg_in = {mag[SAMPLE_BITS-1:0], {FRAC_BITS{1'b0}}};
      end else if (busy_ff) begin
         rem_in   = fits ? trial[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
         shreg_in = {shreg_ff[QUOT_BITS-2:0], fits};
         step_in  = step_ff + STEP_BITS'(1);
         if (step_ff == STEP_BITS'(QUOT_BITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff   <= neg_in;
      step_ff  <= step_in;
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      shreg_ff <= shreg_in;
   end

   assign quot_mag     = {1'b0, shreg_ff};
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = neg_ff ? -quot_mag : quot_mag;

endmodule

>>> src/centered_window_mean.sv
// Centered moving average over sets of signed samples, Q8 result.
// Top level; depends on cwm_pkg, cwm_line and cwm_div.
//
// Usage:
//   req_*  : one sample per transaction, req_set_end on the final sample.
//   rsp_*  : window mean times 256 (truncated toward zero), member count,
//            rsp_run_last on the last result of an input transaction and
//            rsp_set_last on the result for the final position of a set.
//   csr_*  : radius register (reset 1); the user must write it only while
//            the block is idle, which the block itself does not enforce.
// Each result sums its window one sample per cycle, then divides by the
// member count bit-serially, one quotient bit per cycle. An item giving
// one full window holds the input until its result is loaded. A final
// item flushes min(radius, samples - 1) + 1 results, one after another.
// The block takes one input transaction at a time; req_stall is high while
// results of the current one are being computed. The result register lets
// the next transaction in while the last result waits on rsp_stall; a
// stalled result holds and blocks only the next result load.
// Reset clears the set state and the result channel; radius returns to 1.
module centered_window_mean (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [cwm_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   req_set_end,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [cwm_pkg::MEAN_BITS-1:0]   rsp_mean_q8,
   output logic [cwm_pkg::MEMBERS_BITS-1:0]       rsp_members,
   output logic                                   rsp_run_last,
   output logic                                   rsp_set_last,
   input  logic                                   csr_wr_en,
   input  logic [cwm_pkg::RADIUS_BITS-1:0]        csr_wr_data
);
   import cwm_pkg::*;

   cwm_state_type             state_ff, state_in;
   logic [RADIUS_BITS-1:0]    radius_ff;
   logic [COUNT_BITS-1:0]     seen_ff, seen_in;
   logic [COUNT_BITS-1:0]     rad_ff, rad_in;
   logic [COUNT_BITS-1:0]     pos_ff, pos_in;
   logic                      end_ff, end_in;
   logic [AGE_BITS-1:0]       age_ff, age_in;
   logic signed [SUM_BITS-1:0] sum_ff, sum_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [MEAN_BITS-1:0] rsp_mean_ff;
   logic [MEMBERS_BITS-1:0]   rsp_members_ff;
   logic                      rsp_run_last_ff;
   logic                      rsp_set_last_ff;

   logic                      req_accept;
   logic                      rsp_free;
   logic                      rsp_load;
   logic [COUNT_BITS-1:0]     r_eff;
   logic [COUNT_BITS-1:0]     seen_next;
   logic [COUNT_BITS-1:0]     top_pos;
   logic [COUNT_BITS-1:0]     span;
   logic [COUNT_BITS-1:0]     back;
   logic [AGE_BITS-1:0]       hi;
   logic [COUNT_BITS-1:0]     count;
   logic                      job_last;
   logic                      job_set_last;
   logic signed [SAMPLE_BITS-1:0] tap;
   div_req_type               div_req;
   div_rsp_type               div_rsp;

   cwm_line u_line (
      .clock     (clock),
      .push      (req_accept),
      .push_data (req_sample),
      .rd_age    (age_ff),
      .rd_data   (tap)
   );

   cwm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   assign r_eff = (COUNT_BITS'(radius_ff) < COUNT_BITS'(MAX_RADIUS)) ?
                  COUNT_BITS'(radius_ff) : COUNT_BITS'(MAX_RADIUS);
   assign seen_next = (seen_ff < COUNT_BITS'(LINE_DEPTH)) ?
                      seen_ff + COUNT_BITS'(1) : seen_ff;
   assign top_pos = (seen_next - COUNT_BITS'(1) < r_eff) ?
                    seen_next - COUNT_BITS'(1) : r_eff;

   assign span  = seen_ff - COUNT_BITS'(1) - pos_ff;
   assign back  = (span < rad_ff) ? span : rad_ff;
   assign hi    = AGE_BITS'(pos_ff + back);
   assign count = COUNT_BITS'(hi) + COUNT_BITS'(1);

   assign job_last     = end_ff ? (pos_ff == '0) : 1'b1;
   assign job_set_last = end_ff && (pos_ff == '0);

   always_comb begin
      state_in      = state_ff;
      seen_in       = seen_ff;
      rad_in        = rad_ff;
      pos_in        = pos_ff;
      end_in        = end_ff;
      age_in        = age_ff;
      sum_in        = sum_ff;
      rsp_load      = 1'b0;
      div_req.start = 1'b0;
      div_req.sum   = sum_ff;
      div_req.count = count;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               seen_in = seen_next;
               rad_in  = r_eff;
               end_in  = req_set_end;
               age_in  = '0;
               sum_in  = '0;
               if (req_set_end) begin
                  pos_in   = top_pos;
                  state_in = ST_ACCUM;
               end else if (seen_next >= r_eff + COUNT_BITS'(1)) begin
                  pos_in   = r_eff;
                  state_in = ST_ACCUM;
               end
            end
         end
         ST_ACCUM: begin
            sum_in = sum_ff + SUM_BITS'(tap);
            age_in = age_ff + AGE_BITS'(1);
            if (age_ff == hi) begin
               state_in = ST_LAUNCH;
            end
         end
         ST_LAUNCH: begin
            div_req.start = 1'b1;
            state_in      = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_rsp.done && rsp_free) begin
               rsp_load = 1'b1;
               if (job_last) begin
                  if (end_ff) begin
                     seen_in = '0;
                  end
                  state_in = ST_IDLE;
               end else begin
                  pos_in   = pos_ff - COUNT_BITS'(1);
                  age_in   = '0;
                  sum_in   = '0;
                  state_in = ST_ACCUM;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         radius_ff    <= RADIUS_BITS'(RADIUS_RESET);
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
      rad_ff <= rad_in;
      pos_ff <= pos_in;
      end_ff <= end_in;
      age_ff <= age_in;
      sum_ff <= sum_in;
      if (rsp_load) begin
         rsp_mean_ff     <= MEAN_BITS'(div_rsp.quot);
         rsp_members_ff  <= MEMBERS_BITS'(count);
         rsp_run_last_ff <= job_last;
         rsp_set_last_ff <= job_set_last;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_mean_q8  = rsp_mean_ff;
   assign rsp_members  = rsp_members_ff;
   assign rsp_run_last = rsp_run_last_ff;
   assign rsp_set_last = rsp_set_last_ff;

`ifndef ASSERT_OFF
   a_end_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_set_end |=> state_ff == ST_ACCUM)
      else $error("final sample did not start a flush");

   a_age_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACCUM |-> age_ff <= hi)
      else $error("accumulation ran past the window");

   a_set_last_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_set_last |-> rsp_run_last)
      else $error("set_last without run_last");

   a_members_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_members != '0)
      else $error("empty window reported");

   a_seen_bounded: assert property (@(posedge clock) disable iff (reset)
      seen_ff <= COUNT_BITS'(LINE_DEPTH))
      else $error("sample count past line depth");
`endif

endmodule
